// ----- rtl/dsbl_pkg.sv -----
// Shared types and constants for the descending sorted byte list.
package dsbl_pkg;

    // width of one stored letter
    localparam int LETTER_W = 8;

    // controller states
    typedef enum logic
    {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // controller to datapath commands
    typedef struct packed
    {
        logic insert;   // place the incoming letter, restart the listing
        logic rotate;   // current beat taken, step to the next letter
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed
    {
        logic last;     // head of the row is the final letter of the listing
    } dp_status_t;

endpackage

// ----- rtl/descending_sorted_byte_list.sv -----
// Descending sorted byte list: top level joining controller and datapath.
// A letter is placed on its accept beat; the first listing beat is offered the next cycle.
// Each accepted letter is followed by a listing of all N stored letters after the step (at most CAPACITY),
// walked by the single listing port one letter per beat; no new letter is taken until it ends.
// Input stalls from the cycle after the accept beat until the final listing beat is taken.
// Reset (rst_n, asynchronous, active low) empties the list and returns to idle at once.
module descending_sorted_byte_list
#(
    parameter int CAPACITY = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dsbl_pkg::LETTER_W-1:0]   letter,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dsbl_pkg::LETTER_W-1:0]   list_letter,
    output logic                            is_last,
    output logic                            overflow
);

    dsbl_pkg::dp_cmd_t    cmd;
    dsbl_pkg::dp_status_t status;

    dsbl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    dsbl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .letter      (letter),
        .list_letter (list_letter),
        .is_last     (is_last),
        .overflow    (overflow)
    );

endmodule

// ----- rtl/dsbl_ctrl.sv -----
// Controller state machine: accepts one letter, then sequences the listing beats.
module dsbl_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output dsbl_pkg::dp_cmd_t      cmd,
    input  dsbl_pkg::dp_status_t   status
);

    dsbl_pkg::state_t state_reg;
    dsbl_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsbl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            dsbl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.insert = 1'b1;
                    state_next = dsbl_pkg::ST_EMIT;
                end
            end
            dsbl_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.rotate = 1'b1;
                    if (status.last)
                    begin
                        state_next = dsbl_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dsbl_pkg::ST_IDLE;
            end
        endcase
    end

    // the final beat taken always hands back to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dsbl_pkg::ST_EMIT) && cmd.rotate && status.last
        |=> state_reg == dsbl_pkg::ST_IDLE)
        else $error("listing did not end after the final beat");

endmodule

// ----- rtl/dsbl_datapath.sv -----
// Datapath: row of sorted letter cells, entry count, beat index and overflow flag.
module dsbl_datapath
#(
    parameter int CAPACITY = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  dsbl_pkg::dp_cmd_t               cmd,
    output dsbl_pkg::dp_status_t            status,
    input  logic [dsbl_pkg::LETTER_W-1:0]   letter,
    output logic [dsbl_pkg::LETTER_W-1:0]   list_letter,
    output logic                            is_last,
    output logic                            overflow
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [dsbl_pkg::LETTER_W-1:0] cell_reg  [CAPACITY];
    logic [dsbl_pkg::LETTER_W-1:0] cell_next [CAPACITY];
    logic [dsbl_pkg::LETTER_W-1:0] shift_src [CAPACITY];
    logic [dsbl_pkg::LETTER_W-1:0] rot_src   [CAPACITY];
    logic [CAPACITY-1:0]           keep_vec;
    logic [CAPACITY-1:0]           prev_keep;
    logic [CAPACITY-1:0]           wrap_vec;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             count_full;
    logic             do_insert;

    assign count_full = (count_reg == CNT_W'(CAPACITY));
    assign do_insert  = cmd.insert && !count_full;

    // per cell: does the stored letter stay ahead of the new one (ties stay ahead)
    // and where does each cell draw from when shifting or rotating
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        assign keep_vec[k] = (CNT_W'(k) < count_reg) && (cell_reg[k] >= letter);
        assign wrap_vec[k] = (CNT_W'(k) == (count_reg - CNT_W'(1)));

        if (k == 0)
        begin : g_head
            assign prev_keep[k] = 1'b1;
            assign shift_src[k] = letter;
        end
        else
        begin : g_body
            assign prev_keep[k] = keep_vec[k-1];
            assign shift_src[k] = cell_reg[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_tail
            assign rot_src[k] = cell_reg[0];
        end
        else
        begin : g_inner
            assign rot_src[k] = wrap_vec[k] ? cell_reg[0] : cell_reg[k+1];
        end
    end

    // cell update: insert opens a gap at the sorted place, rotate walks the listing
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            cell_next[k] = cell_reg[k];
            if (do_insert)
            begin
                if (!keep_vec[k])
                begin
                    cell_next[k] = prev_keep[k] ? letter : shift_src[k];
                end
            end
            else if (cmd.rotate)
            begin
                cell_next[k] = rot_src[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            cell_reg[k] <= cell_next[k];
        end
    end

    // count, beat index and overflow flag
    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        overflow_next = overflow_reg;
        if (cmd.insert)
        begin
            idx_next      = '0;
            overflow_next = count_full;
            if (!count_full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (cmd.rotate)
        begin
            idx_next = status.last ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            overflow_reg <= overflow_next;
        end
    end

    // beat outputs
    assign status.last = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
    assign list_letter = cell_reg[0];
    assign is_last     = status.last;
    assign overflow    = overflow_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert && !count_full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted letter not counted");

    a_listing_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rotate |=> count_reg == $past(count_reg))
        else $error("entry count changed during listing");

    a_insert_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> idx_reg == '0)
        else $error("listing did not restart at the head");

endmodule
